[rtl/fpls_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpls_pkg
// Shared types and constants of the farthest-point landmark selector.
// ---------------------------------------------------------------------------
package fpls_pkg;

  localparam int MAX_POINTS_DEF  = 256;
  localparam int COORD_BITS_DEF  = 16;
  localparam int NUM_LANES       = 5;

  localparam logic [8:0]  LM_RESET = 9'd16;
  localparam logic [15:0] FW_RESET = 16'd7864;

  localparam logic CFG_LANDMARK = 1'b0;
  localparam logic CFG_WEIGHT   = 1'b1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [2:0] DRAIN_CYC = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SETUP,
    S_CFETCH,
    S_CLATCH,
    S_PASS,
    S_DRAIN,
    S_FILL
  } fpls_state_t;

endpackage

[rtl/fpls_sqcell.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpls_sqcell
// One feature lane: registered square of the absolute difference.
// ---------------------------------------------------------------------------
module fpls_sqcell import fpls_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic [COORD_BITS-1:0]     a,
  input  logic [COORD_BITS-1:0]     b,
  output logic [2*COORD_BITS-1:0]   sq_r
);

  logic [COORD_BITS-1:0] diff;

  assign diff = (a >= b) ? (a - b) : (b - a);

  always_ff @(posedge clk) begin
    sq_r <= (2*COORD_BITS)'(diff) * (2*COORD_BITS)'(diff);
  end

endmodule

[rtl/fpls_dist.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpls_dist
// Distance pipeline: a row of lane cells, lane sums, weighting multiply.
// ---------------------------------------------------------------------------
module fpls_dist import fpls_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  input  logic [$clog2(MAX_POINTS)-1:0]         in_idx,
  input  logic [2*COORD_BITS+2:0]               in_near,
  input  logic [NUM_LANES*COORD_BITS-1:0]       feat_a,
  input  logic [NUM_LANES*COORD_BITS-1:0]       feat_b,
  input  logic [15:0]                           weight,
  output logic                                  out_valid,
  output logic [$clog2(MAX_POINTS)-1:0]         out_idx,
  output logic [2*COORD_BITS+2:0]               out_near,
  output logic [2*COORD_BITS+2:0]               out_dist
);

  localparam int C  = COORD_BITS;
  localparam int IW = $clog2(MAX_POINTS);
  localparam int DW = 2*C+3;

  logic [2*C-1:0]    sq [NUM_LANES];
  logic [2*C:0]      sp2_r;
  logic [2*C+1:0]    fs2_r;
  logic [2*C:0]      sp3_r;
  logic [2*C+17:0]   prod;
  logic [2*C+1:0]    wt3_r;
  logic [2:0]        v_r;
  logic [IW-1:0]     idx_r  [3];
  logic [DW-1:0]     near_r [3];

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    fpls_sqcell #(.COORD_BITS(C)) u_cell (
      .clk  (clk),
      .a    (feat_a[g*C +: C]),
      .b    (feat_b[g*C +: C]),
      .sq_r (sq[g])
    );
  end

  assign prod = (2*C+18)'(fs2_r) * (2*C+18)'(weight);

  always_ff @(posedge clk) begin
    sp2_r <= (2*C+1)'(sq[0]) + (2*C+1)'(sq[1]);
    fs2_r <= (2*C+2)'(sq[2]) + (2*C+2)'(sq[3]) + (2*C+2)'(sq[4]);
    sp3_r <= sp2_r;
    wt3_r <= prod[2*C+17:16];
    idx_r[0]  <= in_idx;
    near_r[0] <= in_near;
    for (int k = 1; k < 3; k++) begin
      idx_r[k]  <= idx_r[k-1];
      near_r[k] <= near_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[1:0], in_valid};
    end
  end

  assign out_valid = v_r[2];
  assign out_idx   = idx_r[2];
  assign out_near  = near_r[2];
  assign out_dist  = DW'(sp3_r) + DW'(wt3_r);

endmodule

[rtl/farthest_point_landmark_selector.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// farthest_point_landmark_selector
// Greedy farthest-point landmark selection over loaded feature points.
// ---------------------------------------------------------------------------
// Input items (in_*): tuser is the opcode. A load item stores one point;
// tlast on a load marks the final point and starts selection. A read item
// returns the load index at a permuted position (landmarks first, then the
// remaining points in ascending order) on the out_* channel; tuser = 1 flags
// a position beyond the loaded count.
// A load is stored on acceptance; a read passes the S_READ state before its
// result is registered. One item is in work at a time.
// Selection after the last load runs L-1 rounds for L landmarks and N
// points: each round sweeps all points once through the distance cell row,
// one point per cycle, set by the single feature-store read port, and a
// final pass fills in the remaining points.
// Reset clears the point count, the chosen flags and the output valid flag,
// and loads landmark_count 16 and feature_weight 7864. A stalled receiver
// holds the result register; no new item is accepted until it is taken.
// Configuration writes (cfg_*) are always ready and take effect at once.
// ---------------------------------------------------------------------------
module farthest_point_landmark_selector import fpls_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // pos_x, pos_y, time_value, gap_value, size_value, position
  input  logic [87:0] in_tdata,
  // opcode
  input  logic        in_tuser,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // point_index
  output logic [7:0]  out_tdata,
  // status
  output logic        out_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_data
);

  localparam int C   = COORD_BITS;
  localparam int IW  = $clog2(MAX_POINTS);
  localparam int CW  = $clog2(MAX_POINTS+1);
  localparam int DW  = 2*C+3;
  localparam int FV  = NUM_LANES*C;
  localparam int LW  = (CW > 9) ? CW : 9;
  localparam int OXW = (IW > 8) ? IW : 8;

  fpls_state_t state_r, state_nxt;

  logic [8:0]            lm_r;
  logic [15:0]           w_r;
  logic [CW-1:0]         loaded_r;
  logic                  set_done_r;
  logic [MAX_POINTS-1:0] chosen_r;
  logic [IW-1:0]         i_r;
  logic [IW-1:0]         l_r;
  logic [CW-1:0]         cursor_r;
  logic [IW-1:0]         center_idx_r;
  logic [FV-1:0]         center_r;
  logic                  first_r;
  logic [2:0]            drain_r;
  logic [IW-1:0]         best_idx_r;
  logic [DW-1:0]         best_val_r;
  logic                  found_r;
  logic                  v1_r;
  logic [IW-1:0]         idx1_r;
  logic                  rd_ok_r;
  logic                  out_valid_r;
  logic [7:0]            out_idx_r;
  logic                  out_st_r;

  logic [FV-1:0]         feat_mem [MAX_POINTS];
  logic [DW-1:0]         nd_mem   [MAX_POINTS];
  logic [IW-1:0]         ord_mem  [MAX_POINTS];
  logic [FV-1:0]         feat_q;
  logic [DW-1:0]         nd_q;
  logic [IW-1:0]         ord_q;

  logic                  in_acc;
  logic                  do_load;
  logic [CW-1:0]         base_cnt;
  logic                  can_store;
  logic [CW-1:0]         loaded_nxt;
  logic [FV-1:0]         in_feat;
  logic [LW-1:0]         p_w;
  logic                  p_ok;
  logic [IW-1:0]         fr_addr;
  logic                  lm_ok;
  logic                  pass_end;
  logic                  fill_end;
  logic                  last_round;
  logic                  ord_we;
  logic [IW-1:0]         ord_wa;
  logic [IW-1:0]         ord_wd;
  logic [OXW-1:0]        ord_wide;

  logic                  dv;
  logic [IW-1:0]         didx;
  logic [DW-1:0]         dnear;
  logic [DW-1:0]         ddist;
  logic [DW-1:0]         newd;
  logic                  take;

  assign cfg_ready = 1'b1;

  assign in_acc    = in_tvalid & in_tready;
  assign do_load   = in_acc && (in_tuser == OP_LOAD);
  assign base_cnt  = set_done_r ? '0 : loaded_r;
  assign can_store = base_cnt < CW'(MAX_POINTS);
  assign loaded_nxt = can_store ? base_cnt + CW'(1) : base_cnt;

  assign in_feat = {C'(in_tdata[79:64]), C'(in_tdata[63:48]), C'(in_tdata[47:32]),
                    C'(in_tdata[31:16]), C'(in_tdata[15:0])};

  assign p_w  = LW'(in_tdata[87:80]);
  assign p_ok = (p_w < LW'(loaded_r)) && (p_w < LW'(MAX_POINTS));

  assign lm_ok      = (lm_r != '0) && (LW'(lm_r) < LW'(loaded_r));
  assign pass_end   = (CW'(i_r) == loaded_r - CW'(1));
  assign fill_end   = pass_end;
  assign last_round = (LW'(l_r) + LW'(1) == LW'(lm_r));
  assign fr_addr    = (state_r == S_CFETCH) ? center_idx_r : i_r;

  fpls_dist #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(C)) u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v1_r),
    .in_idx    (idx1_r),
    .in_near   (nd_q),
    .feat_a    (feat_q),
    .feat_b    (center_r),
    .weight    (w_r),
    .out_valid (dv),
    .out_idx   (didx),
    .out_near  (dnear),
    .out_dist  (ddist)
  );

  assign newd = (first_r || (ddist < dnear)) ? ddist : dnear;
  assign take = dv && !chosen_r[didx] && (!found_r || (newd > best_val_r));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_tuser == OP_READ)) begin
          state_nxt = S_READ;
        end else if (do_load && in_tlast) begin
          state_nxt = S_SETUP;
        end
      end
      S_READ:   state_nxt = S_IDLE;
      S_SETUP: begin
        if (!lm_ok) begin
          state_nxt = S_IDLE;
        end else if (lm_r == 9'd1) begin
          state_nxt = S_FILL;
        end else begin
          state_nxt = S_CFETCH;
        end
      end
      S_CFETCH: state_nxt = S_CLATCH;
      S_CLATCH: state_nxt = S_PASS;
      S_PASS:   if (pass_end) state_nxt = S_DRAIN;
      S_DRAIN: begin
        if (drain_r == DRAIN_CYC) begin
          state_nxt = last_round ? S_FILL : S_CFETCH;
        end
      end
      S_FILL:   if (fill_end) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = (state_r == S_IDLE) && !out_valid_r;
    ord_we = 1'b0;
    ord_wa = '0;
    ord_wd = '0;
    case (state_r)
      S_IDLE: begin
        if (do_load && can_store) begin
          ord_we = 1'b1;
          ord_wa = IW'(base_cnt);
          ord_wd = IW'(base_cnt);
        end
      end
      S_DRAIN: begin
        if (drain_r == DRAIN_CYC) begin
          ord_we = 1'b1;
          ord_wa = l_r;
          ord_wd = best_idx_r;
        end
      end
      S_FILL: begin
        if (!chosen_r[i_r]) begin
          ord_we = 1'b1;
          ord_wa = IW'(cursor_r);
          ord_wd = i_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_load && can_store) feat_mem[IW'(base_cnt)] <= in_feat;
    feat_q <= feat_mem[fr_addr];
    nd_q   <= nd_mem[i_r];
    if (dv) nd_mem[didx] <= newd;
    if (ord_we) ord_mem[ord_wa] <= ord_wd;
    ord_q <= ord_mem[IW'(p_w)];
  end

  assign ord_wide = OXW'(ord_q);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lm_r        <= LM_RESET;
      w_r         <= FW_RESET;
      loaded_r    <= '0;
      set_done_r  <= 1'b0;
      chosen_r    <= '0;
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      first_r     <= 1'b0;
      drain_r     <= '0;
      i_r         <= '0;
      l_r         <= '0;
      cursor_r    <= '0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= (state_r == S_PASS);
      idx1_r  <= i_r;
      if (cfg_valid) begin
        if (cfg_addr == CFG_LANDMARK) lm_r <= cfg_data[8:0];
        if (cfg_addr == CFG_WEIGHT)   w_r  <= cfg_data;
      end
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      if (take) begin
        found_r    <= 1'b1;
        best_idx_r <= didx;
        best_val_r <= newd;
      end
      case (state_r)
        S_IDLE: begin
          if (do_load) begin
            loaded_r   <= loaded_nxt;
            set_done_r <= in_tlast;
          end
          rd_ok_r <= p_ok;
        end
        S_READ: begin
          out_valid_r <= 1'b1;
          out_idx_r   <= rd_ok_r ? ord_wide[7:0] : 8'd0;
          out_st_r    <= !rd_ok_r;
        end
        S_SETUP: begin
          chosen_r     <= '0;
          if (lm_ok) chosen_r[0] <= 1'b1;
          center_idx_r <= '0;
          l_r          <= IW'(1);
          first_r      <= 1'b1;
          i_r          <= '0;
          cursor_r     <= CW'(1);
        end
        S_CLATCH: begin
          center_r <= feat_q;
          found_r  <= 1'b0;
          i_r      <= '0;
          drain_r  <= '0;
        end
        S_PASS: begin
          i_r <= i_r + IW'(1);
        end
        S_DRAIN: begin
          if (drain_r == DRAIN_CYC) begin
            chosen_r[best_idx_r] <= 1'b1;
            center_idx_r         <= best_idx_r;
            l_r                  <= l_r + IW'(1);
            first_r              <= 1'b0;
            i_r                  <= '0;
            cursor_r             <= CW'(lm_r);
          end else begin
            drain_r <= drain_r + 3'd1;
          end
        end
        S_FILL: begin
          i_r <= i_r + IW'(1);
          if (!chosen_r[i_r]) cursor_r <= cursor_r + CW'(1);
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_idx_r;
  assign out_tuser  = out_st_r;

  a_rose_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_READ))
    else $error("result raised outside read");

  a_dist_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    dv |-> (state_r == S_PASS || state_r == S_DRAIN))
    else $error("distance result outside sweep");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILL) |-> (cursor_r <= loaded_r))
    else $error("fill cursor beyond point count");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready)
    else $error("item accepted during work");

endmodule

[test/tb_farthest_point_landmark_selector.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_farthest_point_landmark_selector
// Self-checking bench for the farthest-point landmark selector.
// ---------------------------------------------------------------------------
// Point sets of random size and content are loaded with varied landmark
// counts and weights. Permuted positions are then read back, valid and out of
// range. A local model replays the greedy selection on each accepted tlast
// load. Each read result is checked against the oldest queued prediction.
// The sender idles at random; the receiver stalls at random and in patterns.
// ---------------------------------------------------------------------------
module tb_farthest_point_landmark_selector;
  import fpls_pkg::*;

  typedef struct {
    logic        op;
    logic [15:0] fx, fy, ft, fg, fs;
    logic        last;
    logic [7:0]  pos;
  } fpls_item_t;

  typedef struct {
    logic [7:0] idx;
    logic       bad;
  } lookup_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [87:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_addr = 1'b0;
  logic [15:0] cfg_data = '0;

  farthest_point_landmark_selector dut (.*);

  fpls_item_t  pending_items[$];
  lookup_t     expected_lookups[$];
  int          error_count = 0;
  int          hold_reqs = 0;

  // model state
  logic [15:0]  pt_x[256], pt_y[256], pt_t[256], pt_g[256], pt_s[256];
  logic [63:0]  near_d[256];
  logic         picked[256];
  logic [8:0]   perm[256];
  int           n_loaded = 0;
  logic         set_closed = 1'b0;
  int           lm_count = LM_RESET;
  logic [15:0]  f_weight = FW_RESET;

  initial forever #2 clk = ~clk;

  function automatic logic [63:0] sqd(logic [15:0] a, logic [15:0] b);
    logic [63:0] d;
    d = (a >= b) ? 64'(a - b) : 64'(b - a);
    return d * d;
  endfunction

  function automatic logic [63:0] point_gap(int i, int j);
    logic [63:0] sp, fe;
    sp = sqd(pt_x[i], pt_x[j]) + sqd(pt_y[i], pt_y[j]);
    fe = sqd(pt_t[i], pt_t[j]) + sqd(pt_g[i], pt_g[j]) + sqd(pt_s[i], pt_s[j]);
    return sp + ((fe * 64'(f_weight)) >> 16);
  endfunction

  function automatic void choose_landmarks();
    int          best, cur;
    logic        found;
    logic [63:0] best_v, d;
    for (int i = 0; i < 256; i++) picked[i] = 1'b0;
    for (int i = 0; i < n_loaded; i++) perm[i] = 9'(i);
    if (lm_count == 0 || lm_count >= n_loaded) return;
    picked[0] = 1'b1;
    for (int i = 0; i < n_loaded; i++) near_d[i] = point_gap(i, 0);
    for (int l = 1; l < lm_count; l++) begin
      found = 1'b0;
      best = 0;
      best_v = 0;
      for (int i = 0; i < n_loaded; i++)
        if (!picked[i] && (!found || near_d[i] > best_v)) begin
          found = 1'b1;
          best = i;
          best_v = near_d[i];
        end
      if (!found) break;
      perm[l] = 9'(best);
      picked[best] = 1'b1;
      for (int i = 0; i < n_loaded; i++) begin
        d = point_gap(i, best);
        if (d < near_d[i]) near_d[i] = d;
      end
    end
    cur = lm_count;
    for (int i = 0; i < n_loaded && cur < n_loaded; i++)
      if (!picked[i]) begin
        perm[cur] = 9'(i);
        cur++;
      end
  endfunction

  // predict on every accepted item
  always @(posedge clk) begin
    lookup_t r;
    if (rst_n && in_tvalid && in_tready) begin
      if (in_tuser == OP_LOAD) begin
        if (set_closed) begin
          n_loaded = 0;
          set_closed = 1'b0;
        end
        if (n_loaded < 256) begin
          pt_x[n_loaded] = in_tdata[15:0];
          pt_y[n_loaded] = in_tdata[31:16];
          pt_t[n_loaded] = in_tdata[47:32];
          pt_g[n_loaded] = in_tdata[63:48];
          pt_s[n_loaded] = in_tdata[79:64];
          perm[n_loaded] = 9'(n_loaded);
          n_loaded++;
        end
        if (in_tlast) begin
          choose_landmarks();
          set_closed = 1'b1;
        end
      end else begin
        if (int'(in_tdata[87:80]) < n_loaded) begin
          r.idx = perm[in_tdata[87:80]][7:0];
          r.bad = 1'b0;
        end else begin
          r.idx = 8'd0;
          r.bad = 1'b1;
        end
        expected_lookups.push_back(r);
      end
    end
  end

  // sender: bursts with random gaps
  int burst_left = 4, gap_left = 0;
  always @(posedge clk) begin
    fpls_item_t it;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        it = pending_items.pop_front();
        in_tdata <= {it.pos, it.fs, it.fg, it.ft, it.fy, it.fx};
        in_tuser <= it.op;
        in_tlast <= it.last;
        in_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: rotating stall pattern plus requested long holds
  int cyc = 0, hold_cnt = 0, hold_seen = 0;
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_tready <= 1'b0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_cnt <= 400;
      out_tready <= 1'b0;
    end else begin
      case ((cyc >> 9) % 4)
        0: out_tready <= 1'b1;
        1: out_tready <= $urandom_range(0, 1);
        2: out_tready <= (cyc % 4) != 0;
        default: out_tready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  // check results
  always @(posedge clk) begin
    lookup_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_lookups.size() == 0) begin
        $display("%0t: unexpected result idx=%0d status=%0d", $time, out_tdata, out_tuser);
        error_count++;
      end else begin
        e = expected_lookups.pop_front();
        if (out_tdata !== e.idx) begin
          $display("%0t: point_index expected %0d actual %0d", $time, e.idx, out_tdata);
          error_count++;
        end
        if (out_tuser !== e.bad) begin
          $display("%0t: status expected %0d actual %0d", $time, e.bad, out_tuser);
          error_count++;
        end
      end
    end
  end

  // watchdog
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet > 300000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  int total = 0;

  task automatic push_load(logic [15:0] x, y, t, g, s, logic last);
    fpls_item_t it;
    it = '{OP_LOAD, x, y, t, g, s, last, 8'($urandom)};
    pending_items.push_back(it);
    total++;
  endtask

  task automatic push_read(int p);
    fpls_item_t it;
    it = '{OP_READ, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
           16'($urandom), 1'($urandom), 8'(p)};
    pending_items.push_back(it);
    total++;
  endtask

  function automatic logic [15:0] feat();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 2));
      1: return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // wait until idle; a trailing read drains any selection still running
  task automatic settle();
    while (pending_items.size() != 0 || in_tvalid || expected_lookups.size() != 0)
      @(negedge clk);
    push_read(0);
    while (pending_items.size() != 0 || in_tvalid || expected_lookups.size() != 0)
      @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(logic a, logic [15:0] d);
    cfg_addr <= a;
    cfg_data <= d;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (a == CFG_LANDMARK) lm_count = int'(d[8:0]);
    else f_weight = d;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_set(int n, int reads);
    for (int i = 0; i < n; i++)
      push_load(feat(), feat(), feat(), feat(), feat(), i == n - 1);
    for (int i = 0; i < reads; i++)
      push_read(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                            : $urandom_range(0, n + 1));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // read before any load
    push_read(0);
    settle();
    cfg_write(CFG_LANDMARK, 16'd3);
    cfg_write(CFG_WEIGHT, 16'hFFFF);
    push_load(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    push_load(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    push_load(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 1'b0);
    push_load(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b0);
    push_load(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 1'b1);
    for (int p = 0; p < 6; p++) push_read(p);
    push_read(255);
    // restart after a finished set, reads before its last point
    push_load(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 16'h0F0F, 1'b0);
    push_read(0);
    push_read(1);
    push_load(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 16'h0F0F, 1'b1);
    push_read(1);
    push_read(2);
    settle();
    cfg_write(CFG_LANDMARK, 16'd0);
    cfg_write(CFG_WEIGHT, 16'd0);
    random_set(6, 6);
    settle();
    cfg_write(CFG_LANDMARK, 16'd256);
    random_set(4, 5);
    settle();

    // full store: last point overflows the 256 entries
    cfg_write(CFG_LANDMARK, 16'd255);
    cfg_write(CFG_WEIGHT, 16'd7864);
    for (int i = 0; i < 257; i++)
      push_load(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), i == 256);
    push_read(255);
    push_read(254);
    push_read(0);
    for (int i = 0; i < 6; i++) push_read($urandom_range(0, 255));
    settle();

    while (total < 950) begin
      if ($urandom_range(0, 2) == 0) begin
        cfg_write(CFG_LANDMARK, 16'($urandom_range(0, 14)));
        cfg_write(CFG_WEIGHT, ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom));
      end
      for (int k = 0; k < 4; k++) random_set($urandom_range(1, 20), $urandom_range(4, 14));
      if (hold_reqs == 0 || $urandom_range(0, 5) == 0) begin
        // overfill the result side while the receiver holds off
        hold_reqs++;
        random_set(3, 12);
      end
      settle();
    end

    while (pending_items.size() != 0 || in_tvalid || expected_lookups.size() != 0)
      @(negedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0 && expected_lookups.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

[farthest_point_landmark_selector.f]
rtl/fpls_pkg.sv
rtl/fpls_sqcell.sv
rtl/fpls_dist.sv
rtl/farthest_point_landmark_selector.sv
test/tb_farthest_point_landmark_selector.sv
